>>> hw/rtl/kpx_pkg.sv
// shared types and constants for the key position xor cipher
// used by the register file, sequencer, shared add/xor unit and top level
// no dependencies
package kpx_pkg;

  localparam int unsigned MAX_KEY_BYTES_DEF = 32;   // default key length limit
  localparam int unsigned KEY_REGS          = 4;    // 64-bit key registers
  localparam int unsigned KEY_BYTES_STORED  = 8 * KEY_REGS;
  localparam int unsigned KEY_SEL_W         = $clog2(KEY_BYTES_STORED);
  localparam int unsigned KEY_LEN_W         = 6;
  localparam int unsigned DATA_W            = 8;
  localparam int unsigned APB_DATA_W        = 64;
  localparam int unsigned APB_ADDR_W        = 6;
  localparam int unsigned REG_IDX_W         = 3;

  // register index, byte address is 8 * index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_KEY_0_7   = 3'd0,
    REG_KEY_8_15  = 3'd1,
    REG_KEY_16_23 = 3'd2,
    REG_KEY_24_31 = 3'd3,
    REG_KEY_LEN   = 3'd4
  } reg_idx_e;

  // sequencer commands to the shared unit
  typedef struct packed {
    logic load;  // clear accumulator and position offset
    logic step;  // fold in one key byte
  } kpx_ctrl_t;

endpackage

>>> hw/rtl/kpx_regs.sv
// apb configuration registers: four 64-bit key words and the key length
// depends on kpx_pkg
module kpx_regs (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [kpx_pkg::APB_ADDR_W-1:0]              paddr,
  input  logic [kpx_pkg::APB_DATA_W-1:0]              pwdata,
  output logic [kpx_pkg::APB_DATA_W-1:0]              prdata,
  output logic                                        pready,
  output logic [kpx_pkg::KEY_BYTES_STORED-1:0][7:0]   key_bytes_o,
  output logic [kpx_pkg::KEY_LEN_W-1:0]               key_length_o
);
  import kpx_pkg::*;

  logic [KEY_REGS-1:0][APB_DATA_W-1:0] key_q;
  logic [KEY_LEN_W-1:0]                key_len_q;
  reg_idx_e                            reg_idx;
  logic                                wr_en;

  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY_0_7:   key_q[0]  <= pwdata;
        REG_KEY_8_15:  key_q[1]  <= pwdata;
        REG_KEY_16_23: key_q[2]  <= pwdata;
        REG_KEY_24_31: key_q[3]  <= pwdata;
        REG_KEY_LEN:   key_len_q <= pwdata[KEY_LEN_W-1:0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_0_7:   prdata = key_q[0];
      REG_KEY_8_15:  prdata = key_q[1];
      REG_KEY_16_23: prdata = key_q[2];
      REG_KEY_24_31: prdata = key_q[3];
      REG_KEY_LEN:   prdata = APB_DATA_W'(key_len_q);
      default:       prdata = '0;
    endcase
  end

  // byte 0 of the key sits in the low bits of the first word
  assign key_bytes_o  = key_q;
  assign key_length_o = key_len_q;

endmodule

>>> hw/rtl/kpx_unit.sv
// shared add/xor unit: folds one key byte per step into the keystream byte
// depends on kpx_pkg
module kpx_unit #(
  parameter int unsigned MaxKeyBytes = kpx_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                                      clk_i,
  input  kpx_pkg::kpx_ctrl_t                        ctrl_i,
  input  logic [kpx_pkg::DATA_W-1:0]                pos_i,
  input  logic [$clog2(MaxKeyBytes+1)-1:0]          idx_i,
  input  logic [kpx_pkg::KEY_BYTES_STORED-1:0][7:0] key_bytes_i,
  output logic [kpx_pkg::DATA_W-1:0]                acc_o
);
  import kpx_pkg::*;

  localparam int unsigned CntW = $clog2(MaxKeyBytes + 1);
  localparam int unsigned ExtW = CntW + KEY_SEL_W + 1;

  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] off_q, off_d;   // pos * idx mod 256, built by repeated add
  logic [ExtW-1:0]   idx_ext;
  logic [DATA_W-1:0] key_byte;
  logic [DATA_W-1:0] term;

  assign idx_ext = {{(KEY_SEL_W + 1){1'b0}}, idx_i};

  // key bytes past the stored registers read as zero
  assign key_byte = (idx_ext < ExtW'(KEY_BYTES_STORED)) ?
                    key_bytes_i[idx_ext[KEY_SEL_W-1:0]] : '0;

  assign term = key_byte + off_q;

  always_comb begin
    acc_d = acc_q;
    off_d = off_q;
    if (ctrl_i.load) begin
      acc_d = '0;
      off_d = '0;
    end else if (ctrl_i.step) begin
      acc_d = acc_q ^ term;
      off_d = off_q + pos_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    off_q <= off_d;
  end

  assign acc_o = acc_q;

endmodule

>>> hw/rtl/kpx_seq.sv
// sequencer: input beat capture, key index counter, byte position, output register
// depends on kpx_pkg
module kpx_seq #(
  parameter int unsigned MaxKeyBytes = kpx_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [kpx_pkg::DATA_W-1:0]           data_in_i,
  input  logic                                 message_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [kpx_pkg::DATA_W-1:0]           data_out_o,
  input  logic [kpx_pkg::KEY_LEN_W-1:0]        key_length_i,
  output kpx_pkg::kpx_ctrl_t                   ctrl_o,
  output logic [kpx_pkg::DATA_W-1:0]           pos_o,
  output logic [$clog2(MaxKeyBytes+1)-1:0]     idx_o,
  input  logic [kpx_pkg::DATA_W-1:0]           acc_i
);
  import kpx_pkg::*;

  localparam int unsigned CntW = $clog2(MaxKeyBytes + 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   idx_q;
  logic [CntW-1:0]   len_q;
  logic [CntW-1:0]   len_eff;
  logic [DATA_W-1:0] pos_q;       // position of the next byte
  logic [DATA_W-1:0] pos_work_q;  // position of the byte in flight
  logic [DATA_W-1:0] pos_use;
  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_valid_q;
  logic              in_take;
  logic              last_done;
  logic              out_free;

  // key length saturates at the limit
  assign len_eff = (32'(key_length_i) > 32'(MaxKeyBytes)) ?
                   CntW'(MaxKeyBytes) : CntW'(key_length_i);

  assign pos_use   = message_start_i ? '0 : pos_q;
  assign in_take   = (state_q == S_IDLE) && in_valid_i;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_done = (state_q == S_RUN) && (idx_q == len_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign ctrl_o.load = in_take;
  assign ctrl_o.step = (state_q == S_RUN) && (idx_q != len_q);
  assign pos_o       = pos_work_q;
  assign idx_o       = idx_q;
  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result beat waits in the output register until taken
      out_valid_q <= (out_valid_q && out_stall_i) || (last_done && out_free);
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= '0;
            len_q   <= len_eff;
            pos_q   <= pos_use + 8'd1;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (idx_q != len_q) begin
            idx_q <= idx_q + CntW'(1);
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q     <= data_in_i;
      pos_work_q <= pos_use;
    end
    if (last_done && out_free) begin
      out_data_q <= data_q ^ acc_i;
    end
  end

endmodule

>>> hw/rtl/key_position_xor_cipher_unit.sv
// top level of the key position xor cipher
// depends on kpx_pkg, kpx_regs, kpx_unit, kpx_seq
//
// Each data byte is XORed with a keystream byte: the XOR over key bytes
// j = 0 .. L-1 of (key[j] + position * j) mod 256, where L is key_length
// limited to MAX_KEY_BYTES and position counts bytes modulo 256, cleared by
// message_start on the first byte of a message. For each byte the input beat
// is taken, each key byte is folded in through the single shared add/xor
// unit, and the output register is loaded once free. The input stalls while a
// byte is being worked on; the output register lets the next byte start while
// a finished result beat still waits. L = 0 passes data through unchanged and
// still advances the position. Key registers sit at byte addresses 0, 8, 16,
// 24 and the key length at 32 on the 64-bit apb port.
module key_position_xor_cipher_unit #(
  parameter int unsigned MAX_KEY_BYTES = kpx_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kpx_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [kpx_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [kpx_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kpx_pkg::DATA_W-1:0]        data_in_i,
  input  logic                              message_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kpx_pkg::DATA_W-1:0]        data_out_o
);
  import kpx_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_KEY_BYTES + 1);

  logic [KEY_BYTES_STORED-1:0][7:0] key_bytes;
  logic [KEY_LEN_W-1:0]             key_length;
  kpx_ctrl_t                        ctrl;
  logic [DATA_W-1:0]                pos;
  logic [CntW-1:0]                  idx;
  logic [DATA_W-1:0]                acc;

  kpx_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .key_bytes_o  (key_bytes),
    .key_length_o (key_length)
  );

  kpx_unit #(
    .MaxKeyBytes (MAX_KEY_BYTES)
  ) u_unit (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .pos_i       (pos),
    .idx_i       (idx),
    .key_bytes_i (key_bytes),
    .acc_o       (acc)
  );

  kpx_seq #(
    .MaxKeyBytes (MAX_KEY_BYTES)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_in_i       (data_in_i),
    .message_start_i (message_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_out_o      (data_out_o),
    .key_length_i    (key_length),
    .ctrl_o          (ctrl),
    .pos_o           (pos),
    .idx_o           (idx),
    .acc_i           (acc)
  );

endmodule
